// ===== rtl/irf_pkg.sv =====
package irf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_FIELD_WIDTH = 64;
    localparam int DEF_VALUE_BITS      = 64;

    // Port field widths
    localparam int KIND_W  = 3;
    localparam int SIZE_W  = 2;
    localparam int VALUE_W = 64;
    localparam int FW_W    = 7;
    localparam int CHAR_W  = 8;
    localparam int S_DATA_W = 80;   // value, four flags, width, zero fill to bytes
    localparam int S_USER_W = 5;    // kind, size_mode
    localparam int M_DATA_W = 8;

    // Digit register: 20 BCD digits cover any value up to 64 bits
    localparam int DEC_DIGITS = 20;
    localparam int DIG_W      = 4 * DEC_DIGITS;
    localparam int NDIG_W     = 6;  // up to 32 binary digits

    typedef enum logic [KIND_W-1:0] {
        KIND_DEC  = 3'd0,
        KIND_BIN  = 3'd1,
        KIND_OCT  = 3'd2,
        KIND_HEXL = 3'd3,
        KIND_HEXU = 3'd4
    } t_kind;

    localparam logic [SIZE_W-1:0] SIZE_NORMAL = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_SHORT  = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_LONG   = 2'd2;

    typedef enum logic [1:0] {
        BSEL_16,
        BSEL_32,
        BSEL_LONG
    } t_bsel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DABBLE,
        ST_STRIP,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic dabble;
        logic strip;
        logic pad;
        logic emit;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_dec;
        logic dabble_last;
        logic strip_done;
        logic out_free;
        logic last_char;
    } t_stat;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

endpackage

// ===== rtl/integer_radix_formatter_top.sv =====
// Channel  | Dir | Beat contents
// ---------+-----+--------------------------------------------------------------
// s_axis   | in  | one integer: tdata value/flags/width, tuser kind/size_mode
// m_axis   | out | one ASCII character per beat, tlast on the final character
//
// Per value: accept, setup, B bit steps (decimal only, B = 16, 32 or VALUE_BITS),
// Z leading-zero drops (up to 19 decimal, 31 binary), a strip check, a pad calc,
// then N output beats (N = max(text length, width)).
// Reset: i_rst_n, synchronous, active low; clears the controller and output valid.
// Output stalls hold the emit state; the next value is taken while the final beat waits.
module integer_radix_formatter_top #(
    parameter int MAX_FIELD_WIDTH = irf_pkg::DEF_MAX_FIELD_WIDTH,
    parameter int VALUE_BITS      = irf_pkg::DEF_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [63:0] value, [64] plus_flag, [65] space_flag, [66] hash_flag,
    // [67] sign_suppress, [74:68] field_width, [79:75] zero
    input  logic [irf_pkg::S_DATA_W-1:0]    i_s_axis_tdata,
    // [2:0] kind, [4:3] size_mode
    input  logic [irf_pkg::S_USER_W-1:0]    i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] out_char
    output logic [irf_pkg::M_DATA_W-1:0]    o_m_axis_tdata,
    // last
    output logic                            o_m_axis_tlast
);

    irf_pkg::t_cmd  cmd;
    irf_pkg::t_stat stat;

    // Sequencer: accept, setup, BCD conversion, zero strip, pad calc, emit
    irf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    // Digit register, prefix/pad counters and output register
    irf_datapath #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
        .VALUE_BITS      (VALUE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_s_axis_tuser[2:0]),
        .i_size_mode     (i_s_axis_tuser[4:3]),
        .i_value         (i_s_axis_tdata[63:0]),
        .i_plus_flag     (i_s_axis_tdata[64]),
        .i_space_flag    (i_s_axis_tdata[65]),
        .i_hash_flag     (i_s_axis_tdata[66]),
        .i_sign_suppress (i_s_axis_tdata[67]),
        .i_field_width   (i_s_axis_tdata[74:68]),
        .i_m_tready      (i_m_axis_tready),
        .o_m_tvalid      (o_m_axis_tvalid),
        .o_out_char      (o_m_axis_tdata),
        .o_last          (o_m_axis_tlast)
    );

endmodule

// ===== rtl/irf_ctrl.sv =====
module irf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  irf_pkg::t_stat i_stat,
    output irf_pkg::t_cmd  o_cmd
);

    irf_pkg::t_state r_state;
    irf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            irf_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = irf_pkg::ST_PREP;
                end
            end
            irf_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.is_dec ? irf_pkg::ST_DABBLE : irf_pkg::ST_STRIP;
            end
            irf_pkg::ST_DABBLE: begin
                o_cmd.dabble = 1'b1;
                if (i_stat.dabble_last) begin
                    n_state = irf_pkg::ST_STRIP;
                end
            end
            irf_pkg::ST_STRIP: begin
                if (i_stat.strip_done) begin
                    n_state = irf_pkg::ST_PAD;
                end else begin
                    o_cmd.strip = 1'b1;
                end
            end
            irf_pkg::ST_PAD: begin
                o_cmd.pad = 1'b1;
                n_state   = irf_pkg::ST_EMIT;
            end
            irf_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_char) begin
                        n_state = irf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = irf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/irf_datapath.sv =====
module irf_datapath #(
    parameter int MAX_FIELD_WIDTH = irf_pkg::DEF_MAX_FIELD_WIDTH,
    parameter int VALUE_BITS      = irf_pkg::DEF_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  irf_pkg::t_cmd                  i_cmd,
    output irf_pkg::t_stat                 o_stat,
    input  logic [irf_pkg::KIND_W-1:0]     i_kind,
    input  logic [irf_pkg::SIZE_W-1:0]     i_size_mode,
    input  logic [irf_pkg::VALUE_W-1:0]    i_value,
    input  logic                           i_plus_flag,
    input  logic                           i_space_flag,
    input  logic                           i_hash_flag,
    input  logic                           i_sign_suppress,
    input  logic [irf_pkg::FW_W-1:0]       i_field_width,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [irf_pkg::CHAR_W-1:0]     o_out_char,
    output logic                           o_last
);

    localparam int VB   = VALUE_BITS;
    localparam int DW   = irf_pkg::DIG_W;
    localparam int NW   = irf_pkg::NDIG_W;
    localparam int PW   = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int CW   = $clog2(VALUE_BITS + 1);
    // digit counts per kind and size
    localparam int OCT_ND_L = (VALUE_BITS + 2) / 3;
    localparam int HEX_ND_L = (VALUE_BITS + 3) / 4;
    // left shift that puts the top digit slot at the top of the digit register
    localparam int SH_OCT16 = DW - 3 * 6;
    localparam int SH_OCT32 = DW - 3 * 11;
    localparam int SH_OCTL  = DW - 3 * OCT_ND_L;
    localparam int SH_HEX16 = DW - 16;
    localparam int SH_HEX32 = DW - 32;
    localparam int SH_HEXL  = DW - 4 * HEX_ND_L;
    localparam int SH_BIN   = DW - 32;

    irf_pkg::t_kind r_kind;
    irf_pkg::t_bsel r_bsel;
    logic           r_plus;
    logic           r_space;
    logic           r_hash;
    logic           r_supp;
    logic [PW-1:0]  r_width;
    logic [VB-1:0]  r_bin;
    logic [DW-1:0]  r_dig;
    logic [CW-1:0]  r_cnt;
    logic [NW-1:0]  r_ndig;
    logic [1:0]     r_plen;
    logic [15:0]    r_pfx;
    logic [PW-1:0]  r_pad;
    logic                       r_ovalid;
    logic [irf_pkg::CHAR_W-1:0] r_ochar;
    logic                       r_olast;

    irf_pkg::t_kind n_kind;
    irf_pkg::t_bsel n_bsel;
    logic [PW-1:0]  n_width;
    logic [VB-1:0]  n_bin;
    logic [DW-1:0]  n_dig;
    logic [CW-1:0]  n_cnt;
    logic [NW-1:0]  n_ndig;
    logic [1:0]     n_plen;
    logic [15:0]    n_pfx;
    logic [PW-1:0]  n_pad;
    logic                       n_ovalid;
    logic [irf_pkg::CHAR_W-1:0] n_ochar;
    logic                       n_olast;

    logic [VB-1:0]  mask;
    logic           sign_bit;
    logic           neg;
    logic [VB-1:0]  mag;
    logic [3:0]     top_digit;
    logic [DW-1:0]  dig_shifted;
    logic [DW-1:0]  bcd_adj;
    logic [7:0]     len8;
    logic [7:0]     width8;
    logic           last_char;

    function automatic logic [irf_pkg::CHAR_W-1:0] digit_char(
        input logic [3:0] d,
        input logic       upper
    );
        logic [irf_pkg::CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = irf_pkg::CH_ZERO + irf_pkg::CHAR_W'(d);
        end else if (upper) begin
            c = irf_pkg::CH_UA + irf_pkg::CHAR_W'(d - 4'd10);
        end else begin
            c = irf_pkg::CH_LA + irf_pkg::CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

    // Value mask and sign bit for the selected size
    always_comb begin
        case (r_bsel)
            irf_pkg::BSEL_16: begin
                mask     = VB'(16'hFFFF);
                sign_bit = r_bin[15];
            end
            irf_pkg::BSEL_32: begin
                mask     = VB'(32'hFFFF_FFFF);
                sign_bit = r_bin[31];
            end
            default: begin
                mask     = '1;
                sign_bit = r_bin[VB-1];
            end
        endcase
        neg = (r_kind == irf_pkg::KIND_DEC) && sign_bit;
        mag = neg ? ((~r_bin + VB'(1)) & mask) : r_bin;
    end

    // Top digit and one-digit left shift, by radix
    always_comb begin
        case (r_kind)
            irf_pkg::KIND_BIN: begin
                top_digit   = {3'b000, r_dig[DW-1]};
                dig_shifted = r_dig << 1;
            end
            irf_pkg::KIND_OCT: begin
                top_digit   = {1'b0, r_dig[DW-1 -: 3]};
                dig_shifted = r_dig << 3;
            end
            default: begin
                top_digit   = r_dig[DW-1 -: 4];
                dig_shifted = r_dig << 4;
            end
        endcase
    end

    // Double-dabble add-3 on every BCD digit
    always_comb begin
        for (int i = 0; i < irf_pkg::DEC_DIGITS; i++) begin
            if (r_dig[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_dig[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_dig[4*i +: 4];
            end
        end
    end

    assign len8      = 8'(r_ndig) + 8'(r_plen);
    assign width8    = 8'(r_width);
    assign last_char = (r_pad == '0) && (r_plen == 2'd0) && (r_ndig == NW'(1));

    always_comb begin
        n_kind   = r_kind;
        n_bsel   = r_bsel;
        n_width  = r_width;
        n_bin    = r_bin;
        n_dig    = r_dig;
        n_cnt    = r_cnt;
        n_ndig   = r_ndig;
        n_plen   = r_plen;
        n_pfx    = r_pfx;
        n_pad    = r_pad;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        n_ovalid = r_ovalid;
        if (i_m_tready) begin
            n_ovalid = 1'b0;
        end

        if (i_cmd.load) begin
            if (i_kind > irf_pkg::KIND_W'(irf_pkg::KIND_HEXU)) begin
                n_kind = irf_pkg::KIND_DEC;
            end else begin
                n_kind = irf_pkg::t_kind'(i_kind);
            end
            if (n_kind == irf_pkg::KIND_BIN) begin
                n_bsel = irf_pkg::BSEL_32;
            end else if (i_size_mode == irf_pkg::SIZE_SHORT) begin
                n_bsel = irf_pkg::BSEL_16;
            end else if (i_size_mode == irf_pkg::SIZE_LONG) begin
                n_bsel = irf_pkg::BSEL_LONG;
            end else begin
                n_bsel = irf_pkg::BSEL_32;
            end
            case (n_bsel)
                irf_pkg::BSEL_16: n_bin = VB'(i_value[15:0]);
                irf_pkg::BSEL_32: n_bin = VB'(i_value[31:0]);
                default:          n_bin = i_value[VB-1:0];
            endcase
            if (i_field_width > irf_pkg::FW_W'(MAX_FIELD_WIDTH)) begin
                n_width = PW'(MAX_FIELD_WIDTH);
            end else begin
                n_width = PW'(i_field_width);
            end
        end

        if (i_cmd.prep) begin
            n_pfx  = '0;
            n_plen = 2'd0;
            case (r_kind)
                irf_pkg::KIND_DEC: begin
                    if (neg) begin
                        n_pfx  = {irf_pkg::CH_MINUS, 8'h00};
                        n_plen = 2'd1;
                    end else if (r_plus && !r_supp) begin
                        n_pfx  = {irf_pkg::CH_PLUS, 8'h00};
                        n_plen = 2'd1;
                    end else if (r_space && !r_supp) begin
                        n_pfx  = {irf_pkg::CH_SPACE, 8'h00};
                        n_plen = 2'd1;
                    end
                end
                irf_pkg::KIND_BIN: begin
                    if (r_hash) begin
                        n_pfx  = {irf_pkg::CH_ZERO, irf_pkg::CH_LB};
                        n_plen = 2'd2;
                    end
                end
                irf_pkg::KIND_OCT: begin
                    if (r_hash && (r_bin != '0)) begin
                        n_pfx  = {irf_pkg::CH_ZERO, 8'h00};
                        n_plen = 2'd1;
                    end
                end
                irf_pkg::KIND_HEXL: begin
                    if (r_hash && (r_bin != '0)) begin
                        n_pfx  = {irf_pkg::CH_ZERO, irf_pkg::CH_LX};
                        n_plen = 2'd2;
                    end
                end
                default: begin
                    if (r_hash && (r_bin != '0)) begin
                        n_pfx  = {irf_pkg::CH_ZERO, irf_pkg::CH_UX};
                        n_plen = 2'd2;
                    end
                end
            endcase
            case (r_kind)
                irf_pkg::KIND_DEC: begin
                    n_dig  = '0;
                    n_ndig = NW'(irf_pkg::DEC_DIGITS);
                    case (r_bsel)
                        irf_pkg::BSEL_16: begin
                            n_bin = mag << (VB - 16);
                            n_cnt = CW'(16);
                        end
                        irf_pkg::BSEL_32: begin
                            n_bin = mag << (VB - 32);
                            n_cnt = CW'(32);
                        end
                        default: begin
                            n_bin = mag;
                            n_cnt = CW'(VB);
                        end
                    endcase
                end
                irf_pkg::KIND_BIN: begin
                    n_dig  = DW'(mag) << SH_BIN;
                    n_ndig = NW'(32);
                end
                irf_pkg::KIND_OCT: begin
                    case (r_bsel)
                        irf_pkg::BSEL_16: begin
                            n_dig  = DW'(mag) << SH_OCT16;
                            n_ndig = NW'(6);
                        end
                        irf_pkg::BSEL_32: begin
                            n_dig  = DW'(mag) << SH_OCT32;
                            n_ndig = NW'(11);
                        end
                        default: begin
                            n_dig  = DW'(mag) << SH_OCTL;
                            n_ndig = NW'(OCT_ND_L);
                        end
                    endcase
                end
                default: begin
                    case (r_bsel)
                        irf_pkg::BSEL_16: begin
                            n_dig  = DW'(mag) << SH_HEX16;
                            n_ndig = NW'(4);
                        end
                        irf_pkg::BSEL_32: begin
                            n_dig  = DW'(mag) << SH_HEX32;
                            n_ndig = NW'(8);
                        end
                        default: begin
                            n_dig  = DW'(mag) << SH_HEXL;
                            n_ndig = NW'(HEX_ND_L);
                        end
                    endcase
                end
            endcase
        end

        // one binary bit into the BCD digits, MSB first
        if (i_cmd.dabble) begin
            n_dig = {bcd_adj[DW-2:0], r_bin[VB-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt - CW'(1);
        end

        // drop a leading zero digit
        if (i_cmd.strip) begin
            n_dig  = dig_shifted;
            n_ndig = r_ndig - NW'(1);
        end

        if (i_cmd.pad) begin
            if (width8 > len8) begin
                n_pad = PW'(width8 - len8);
            end else begin
                n_pad = '0;
            end
        end

        // spaces, then prefix, then digits
        if (i_cmd.emit) begin
            n_ovalid = 1'b1;
            n_olast  = last_char;
            if (r_pad != '0) begin
                n_ochar = irf_pkg::CH_SPACE;
                n_pad   = r_pad - PW'(1);
            end else if (r_plen != 2'd0) begin
                n_ochar = r_pfx[15:8];
                n_pfx   = {r_pfx[7:0], 8'h00};
                n_plen  = r_plen - 2'd1;
            end else begin
                n_ochar = digit_char(top_digit, r_kind == irf_pkg::KIND_HEXU);
                n_dig   = dig_shifted;
                n_ndig  = r_ndig - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_bsel  <= n_bsel;
        r_width <= n_width;
        r_bin   <= n_bin;
        r_dig   <= n_dig;
        r_cnt   <= n_cnt;
        r_ndig  <= n_ndig;
        r_plen  <= n_plen;
        r_pfx   <= n_pfx;
        r_pad   <= n_pad;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        if (i_cmd.load) begin
            r_plus  <= i_plus_flag;
            r_space <= i_space_flag;
            r_hash  <= i_hash_flag;
            r_supp  <= i_sign_suppress;
        end
    end

    assign o_stat.is_dec      = (r_kind == irf_pkg::KIND_DEC);
    assign o_stat.dabble_last = (r_cnt == CW'(1));
    assign o_stat.strip_done  = (top_digit != 4'd0) || (r_ndig == NW'(1));
    assign o_stat.out_free    = !r_ovalid || i_m_tready;
    assign o_stat.last_char   = last_char;

    assign o_m_tvalid = r_ovalid;
    assign o_out_char = r_ochar;
    assign o_last     = r_olast;

endmodule
